### src/rpn_pkg.sv
// Shared types, sizes and codes for the reverse-Polish expression evaluator.
package rpn_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_W      = 32;
  localparam int NUM_W       = 31;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_NUMBER   = 2'd0,
    KIND_OPERATOR = 2'd1,
    KIND_INVALID  = 2'd2,
    KIND_END      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FEW      = 3'd1,
    ST_DIVZERO  = 3'd2,
    ST_INVALID  = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_LEFTOVER = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push_num;     // write the incoming number at the top and count up
    logic    set_err;      // latch err_code
    status_t err_code;
    logic    latch_opc;    // keep the operator code of the accepted word
    logic    rd_top;       // read the entry at count - 1
    logic    rd_second;    // read the entry at count - 2
    logic    rd_zero;      // read the bottom entry
    logic    cap_b;        // right operand from read data
    logic    cap_a_pop;    // left operand from read data, count down by two
    logic    calc;         // result register from add, subtract or multiply
    logic    div_start;    // start the divider
    logic    div_capture;  // result register from the divider
    logic    write_res;    // push the result register
    logic    load_out;     // load the output word and clear the expression
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic    err_set;
    logic    full;
    logic    few;
    logic    b_zero;
    logic    div_done;
    opcode_t opc;
  } dp_stat_t;

endpackage

### src/rpn_stack_evaluator_top.sv
// Top level of the reverse-Polish expression evaluator.
//
//   Channel  Direction  Handshake            Word
//   in       input      in_valid/in_ready    kind, number_value, operator_code
//   out      output     out_valid/out_ready  value, status
//
// A number, an invalid token or any token but the end token after an error is handled in the idle state.
// Add, subtract and multiply run two stack reads, compute, then push.
// Divide runs the same reads, then waits on the divider at one quotient bit a cycle, then pushes.
// The end token reads the bottom entry, then waits while a previous output word is not taken.
// Reset is synchronous; it empties the stack and clears the error and the output valid flag.
// A stalled output word does not block number and operator tokens.
module rpn_stack_evaluator_top import rpn_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               kind,
  input  logic [NUM_W-1:0]         number_value,
  input  logic [1:0]               operator_code,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] value,
  output logic [2:0]               status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpn_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .number_value  (number_value),
    .operator_code (operator_code),
    .stat          (stat),
    .value         (value),
    .status        (status)
  );

endmodule

### src/rpn_div.sv
// Iterative signed truncating divider, one quotient bit per cycle.
module rpn_div import rpn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DATA_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic              neg;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] mag_b;

  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] mag_a_in;
  logic [DATA_W-1:0] mag_b_in;

  // Magnitudes of the operands; the most negative value maps onto itself.
  always_comb begin
    mag_a_in = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
    mag_b_in = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
  end

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    rem_sh = {rem, quo[DATA_W-1]};
    diff   = rem_sh - {1'b0, mag_b};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(DATA_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= mag_a_in;
      mag_b <= mag_b_in;
      neg   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

### src/rpn_dp.sv
// Datapath: operand stack memory, count, error latch, ALU, divider, output word.
module rpn_dp import rpn_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [NUM_W-1:0]   number_value,
  input  logic [1:0]         operator_code,
  output dp_stat_t           stat,
  output logic signed [DATA_W-1:0] value,
  output logic [2:0]         status
);

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata;
  logic [CNT_W-1:0]  count;
  status_t           err;
  opcode_t           opc;
  logic [DATA_W-1:0] op_a;
  logic [DATA_W-1:0] op_b;
  logic [DATA_W-1:0] res;

  logic [DATA_W-1:0] div_q;
  logic              div_done;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_en;
  logic              wr_en;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] alu_out;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  status_t           end_status;

  assign cnt_m1 = count - 1'b1;
  assign cnt_m2 = count - 2'd2;

  // Read address selection.
  always_comb begin
    rd_en = cmd.rd_top | cmd.rd_second | cmd.rd_zero;
    if (cmd.rd_top) begin
      rd_addr = cnt_m1[IDX_W-1:0];
    end else if (cmd.rd_second) begin
      rd_addr = cnt_m2[IDX_W-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  assign wr_en = cmd.push_num | cmd.write_res;
  assign wdata = cmd.push_num ? {1'b0, number_value} : res;

  // Stack memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[count[IDX_W-1:0]] <= wdata;
    end
    if (rd_en) begin
      rdata <= stack_mem[rd_addr];
    end
  end

  // Add, subtract and the low word of the product, all wrapping.
  always_comb begin
    case (opc)
      OP_ADD:  alu_out = op_a + op_b;
      OP_SUB:  alu_out = op_a - op_b;
      OP_MUL:  alu_out = op_a * op_b;
      default: alu_out = '0;
    endcase
  end

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (op_a),
    .divisor  (op_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // Stack depth and the first error of the expression.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err   <= ST_OK;
    end else if (cmd.load_out) begin
      count <= '0;
      err   <= ST_OK;
    end else begin
      if (cmd.push_num || cmd.write_res) begin
        count <= count + 1'b1;
      end else if (cmd.cap_a_pop) begin
        count <= cnt_m2;
      end
      if (cmd.set_err) begin
        err <= cmd.err_code;
      end
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_opc) begin
      opc <= opcode_t'(operator_code);
    end
    if (cmd.cap_b) begin
      op_b <= rdata;
    end
    if (cmd.cap_a_pop) begin
      op_a <= rdata;
    end
    if (cmd.calc) begin
      res <= alu_out;
    end else if (cmd.div_capture) begin
      res <= div_q;
    end
  end

  // Final status of the expression.
  always_comb begin
    if (err != ST_OK) begin
      end_status = err;
    end else if (count == '0) begin
      end_status = ST_EMPTY;
    end else if (count != CNT_W'(1)) begin
      end_status = ST_LEFTOVER;
    end else begin
      end_status = ST_OK;
    end
  end

  // Output word.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= end_status;
      value  <= (end_status == ST_OK) ? rdata : '0;
    end
  end

  always_comb begin
    stat.err_set  = (err != ST_OK);
    stat.full     = (count >= CNT_W'(STACK_DEPTH));
    stat.few      = (count < CNT_W'(2));
    stat.b_zero   = (op_b == '0);
    stat.div_done = div_done;
    stat.opc      = opc;
  end

endmodule

### src/rpn_ctrl.sv
// Controller: token sequencing state machine and output word valid flag.
module rpn_ctrl import rpn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [1:0] kind,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_B,
    S_RD_A,
    S_EXEC,
    S_DIV,
    S_WR,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind_t'(kind) == KIND_END) begin
            cmd.rd_zero = 1'b1;
            state_next  = S_FIN;
          end else if (!stat.err_set) begin
            case (kind_t'(kind))
              KIND_NUMBER: begin
                if (stat.full) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_OVERFLOW;
                end else begin
                  cmd.push_num = 1'b1;
                end
              end
              KIND_OPERATOR: begin
                if (stat.few) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_FEW;
                end else begin
                  cmd.rd_top    = 1'b1;
                  cmd.latch_opc = 1'b1;
                  state_next    = S_RD_B;
                end
              end
              default: begin
                cmd.set_err  = 1'b1;
                cmd.err_code = ST_INVALID;
              end
            endcase
          end
        end
      end
      S_RD_B: begin
        cmd.cap_b     = 1'b1;
        cmd.rd_second = 1'b1;
        state_next    = S_RD_A;
      end
      S_RD_A: begin
        cmd.cap_a_pop = 1'b1;
        state_next    = S_EXEC;
      end
      S_EXEC: begin
        if (stat.opc == OP_DIV) begin
          if (stat.b_zero) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_DIVZERO;
            state_next   = S_IDLE;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end else begin
          cmd.calc   = 1'b1;
          state_next = S_WR;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_capture = 1'b1;
          state_next      = S_WR;
        end
      end
      S_WR: begin
        cmd.write_res = 1'b1;
        state_next    = S_IDLE;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/rpn_checker.sv
// Port-level checks for the evaluator and their binding to the top level.
module rpn_checker import rpn_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value,
  input logic [2:0]  status
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status))
    else $error("output word changed while stalled");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  // Status codes stay within the defined set.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_OVERFLOW)
    else $error("undefined status code");

  // A failed expression carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> value == 32'd0)
    else $error("nonzero value with error status");

  // Number and invalid tokens finish in the cycle they are taken.
  a_single_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind == KIND_NUMBER || kind == KIND_INVALID) |=> in_ready)
    else $error("single-cycle token held the input");

endmodule

bind rpn_stack_evaluator_top rpn_checker u_rpn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .kind      (kind),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value     (value),
  .status    (status)
);

### dv/tb_rpn_stack_evaluator_top.sv
// Self-checking testbench for the reverse-Polish expression evaluator top level.
`timescale 1ns / 1ps

module tb_rpn_stack_evaluator_top;
  import rpn_pkg::*;

  localparam int RANDOM_TOKENS = 915;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 50;

  typedef struct {
    kind_t              kind;
    logic [NUM_W-1:0]   num;
    opcode_t            op;
  } token_t;

  typedef struct {
    logic [DATA_W-1:0]  value;
    status_t            status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  kind_t                    kind = KIND_NUMBER;
  logic [NUM_W-1:0]         number_value = '0;
  opcode_t                  operator_code = OP_ADD;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] value;
  logic [2:0]               status;

  // Tokens waiting to be sent and answers waiting to come back.
  token_t  token_queue[$];
  answer_t answer_queue[$];

  // Shadow copy of the evaluator state.
  logic [DATA_W-1:0] operand_mem [STACK_DEPTH];
  int                operand_count = 0;
  status_t           first_error = ST_OK;

  int tokens_queued   = 0;
  int tokens_taken    = 0;
  int results_checked = 0;
  int failures        = 0;
  int stall_cycles    = 0;
  int status_seen [8];

  // Idling is switched off for a stretch of the run.
  logic no_gaps;
  assign no_gaps = (tokens_taken >= 400) && (tokens_taken < 560);

  rpn_stack_evaluator_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .number_value  (number_value),
    .operator_code (operator_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .value         (value),
    .status        (status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Apply one accepted token to the shadow state and queue the answer it causes.
  task automatic evaluate_token(input kind_t k, input logic [NUM_W-1:0] num,
                                input opcode_t op);
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] mag_l;
    logic [DATA_W-1:0] mag_r;
    logic [DATA_W-1:0] quo;
    answer_t           ans;
    if (k == KIND_END) begin
      ans.value = '0;
      if (first_error != ST_OK) begin
        ans.status = first_error;
      end else if (operand_count == 0) begin
        ans.status = ST_EMPTY;
      end else if (operand_count != 1) begin
        ans.status = ST_LEFTOVER;
      end else begin
        ans.status = ST_OK;
        ans.value  = operand_mem[0];
      end
      answer_queue.push_back(ans);
      operand_count = 0;
      first_error   = ST_OK;
    end else if (first_error == ST_OK) begin
      case (k)
        KIND_NUMBER: begin
          if (operand_count >= STACK_DEPTH) begin
            first_error = ST_OVERFLOW;
          end else begin
            operand_mem[operand_count] = {1'b0, num};
            operand_count++;
          end
        end
        KIND_OPERATOR: begin
          if (operand_count < 2) begin
            first_error = ST_FEW;
          end else begin
            rhs = operand_mem[operand_count - 1];
            lhs = operand_mem[operand_count - 2];
            operand_count -= 2;
            res = '0;
            case (op)
              OP_ADD: res = lhs + rhs;
              OP_SUB: res = lhs - rhs;
              OP_MUL: res = lhs * rhs;
              default: begin
                // Truncating signed divide done on magnitudes, so that the most
                // negative value over minus one wraps back to itself.
                if (rhs == '0) begin
                  first_error = ST_DIVZERO;
                end else begin
                  mag_l = lhs[DATA_W-1] ? ('0 - lhs) : lhs;
                  mag_r = rhs[DATA_W-1] ? ('0 - rhs) : rhs;
                  quo   = mag_l / mag_r;
                  res   = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? ('0 - quo) : quo;
                end
              end
            endcase
            if (first_error == ST_OK) begin
              operand_mem[operand_count] = res;
              operand_count++;
            end
          end
        end
        default: first_error = ST_INVALID;
      endcase
    end
  endtask

  // Token builders; fields that the token does not use get random bits.
  task automatic add_num(input logic [NUM_W-1:0] v);
    token_queue.push_back('{KIND_NUMBER, v, opcode_t'($urandom_range(0, 3))});
    tokens_queued++;
  endtask

  task automatic add_op(input opcode_t o);
    token_queue.push_back('{KIND_OPERATOR, NUM_W'($urandom), o});
    tokens_queued++;
  endtask

  task automatic add_other(input kind_t k);
    token_queue.push_back('{k, NUM_W'($urandom), opcode_t'($urandom_range(0, 3))});
    tokens_queued++;
  endtask

  // Operand values lean toward zero, one, the maximum and small numbers.
  function automatic logic [NUM_W-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return NUM_W'(1);
      2:       return '1;
      3, 4, 5: return NUM_W'($urandom_range(0, 15));
      default: return NUM_W'($urandom);
    endcase
  endfunction

  // Emit a well-formed expression with the given number of operands. A tweak
  // of 1 adds a stray number, 2 adds a stray operator, before the end token.
  task automatic gen_expression(input int operands, input int tweak);
    int depth;
    int left;
    depth = 0;
    left  = operands;
    while (left > 0 || depth > 1) begin
      if (depth >= 2 && (left == 0 || $urandom_range(0, 1) == 1)) begin
        add_op(opcode_t'($urandom_range(0, 3)));
        depth--;
      end else begin
        add_num(rand_operand());
        depth++;
        left--;
      end
    end
    if (tweak == 1) begin
      add_num(rand_operand());
    end else if (tweak == 2) begin
      add_op(opcode_t'($urandom_range(0, 3)));
    end
    add_other(KIND_END);
  endtask

  // Stimulus, reset and end of run.
  initial begin
    int base;
    int pick;
    int n;
    // End token on an empty stack.
    add_other(KIND_END);
    // Build the most negative value, divide it by minus one: wraps to itself.
    add_num('0);
    add_num('1);
    add_op(OP_SUB);
    add_num(NUM_W'(1));
    add_op(OP_SUB);
    add_num('0);
    add_num(NUM_W'(1));
    add_op(OP_SUB);
    add_op(OP_DIV);
    add_other(KIND_END);
    // Largest operands multiplied, then a final result of minus one.
    add_num('1);
    add_num('1);
    add_op(OP_MUL);
    add_num(NUM_W'(2));
    add_op(OP_SUB);
    add_other(KIND_END);
    // Too few operands; the invalid token after it is ignored.
    add_num(NUM_W'(3));
    add_op(OP_ADD);
    add_other(KIND_INVALID);
    add_other(KIND_END);
    // Divide by zero.
    add_num(NUM_W'(4));
    add_num('0);
    add_op(OP_DIV);
    add_other(KIND_END);
    // Invalid token, then values left over at the end.
    add_other(KIND_INVALID);
    add_other(KIND_END);
    add_num(NUM_W'(1));
    add_num(NUM_W'(2));
    add_other(KIND_END);

    // Random expressions: mostly well-formed, some broken, some deep.
    base = tokens_queued;
    while (tokens_queued - base < RANDOM_TOKENS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        gen_expression(n, 0);
      end else if (pick < 75) begin
        gen_expression($urandom_range(1, 6), $urandom_range(1, 2));
      end else if (pick < 80) begin
        // Fill the stack to one below its depth or to its depth, or one past it for an overflow.
        n = STACK_DEPTH - 1 + $urandom_range(0, 2);
        repeat (n) add_num(rand_operand());
        if (n > STACK_DEPTH) begin
          repeat ($urandom_range(1, 3)) add_other(kind_t'($urandom_range(0, 2)));
        end else begin
          repeat (n - 1) add_op(opcode_t'($urandom_range(0, 3)));
        end
        add_other(KIND_END);
      end else begin
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 3) == 0) begin
            add_other(KIND_INVALID);
          end else if ($urandom_range(0, 1) == 0) begin
            add_num(rand_operand());
          end else begin
            add_op(opcode_t'($urandom_range(0, 3)));
          end
        end
        add_other(KIND_END);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (token_queue.size() != 0 || in_valid || answer_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d tokens and checked %0d results.", tokens_taken, results_checked);
    $display("Results by status: ok %0d, few %0d, div0 %0d, invalid %0d, empty %0d, %s",
             status_seen[ST_OK], status_seen[ST_FEW], status_seen[ST_DIVZERO],
             status_seen[ST_INVALID], status_seen[ST_EMPTY],
             $sformatf("leftover %0d, overflow %0d",
                       status_seen[ST_LEFTOVER], status_seen[ST_OVERFLOW]));
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Input driver: predicts on acceptance, then offers the next word or a gap.
  always @(posedge clk) begin : drive_words
    token_t next_tok;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        evaluate_token(kind, number_value, operator_code);
        tokens_taken++;
      end
      if (!in_valid || in_ready) begin
        if (token_queue.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 18)) begin
          next_tok      = token_queue.pop_front();
          kind          <= next_tok.kind;
          number_value  <= next_tok.num;
          operator_code <= next_tok.op;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output backpressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_gaps || ($urandom_range(0, 99) >= 18);
    end
  end

  // Output monitor: each accepted word is checked against the oldest answer.
  always @(posedge clk) begin : check_words
    answer_t head;
    if (!rst && out_valid && out_ready) begin
      if (answer_queue.size() == 0) begin
        $error("Unexpected result word: value %0d, status %0d", value, status);
        failures++;
      end else begin
        head = answer_queue.pop_front();
        if (value !== head.value) begin
          $error("Field value: expected %0d, got %0d", $signed(head.value), value);
          failures++;
        end
        if (status !== head.status) begin
          $error("Field status: expected %0d, got %0d", head.status, status);
          failures++;
        end
        results_checked++;
        status_seen[status]++;
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

### sim.f
src/rpn_pkg.sv
src/rpn_div.sv
src/rpn_dp.sv
src/rpn_ctrl.sv
src/rpn_stack_evaluator_top.sv
src/rpn_checker.sv
dv/tb_rpn_stack_evaluator_top.sv
